// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the palette matcher.
// Depends on nothing; files that check their own logic include it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property holds in the same cycle as its trigger.
`define PNC_ASSERT_NOW(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error(msg);

// The property holds in the cycle after its trigger.
`define PNC_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== sv/pnc_pkg.sv =====
// Package of the palette nearest-color matcher: widths, codes and state type.
// Depends on nothing; used by the top level and the palette RAM.
package pnc_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int CH_W                = 6;
    localparam int COLOR_W             = 3 * CH_W;
    // Largest distance is 3 * 63 * 63 = 11907, which fits in 14 bits.
    localparam int DIST_W              = 14;
    localparam logic [DIST_W-1:0] NO_DIST = '1;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_MATCH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } pnc_state_t;

endpackage

// ===== sv/pnc_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on pnc_pkg for its default width and depth.
module pnc_ram
    import pnc_pkg::*;
#(
    parameter int WIDTH = COLOR_W,
    parameter int DEPTH = PALETTE_ENTRIES_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/palette_nearest_color_match.sv =====
// Operation: a write stores an entry and gives no result; a match scans the palette
// and gives its result once the scan has drained through the pipeline and the done state.
// Flow: s_ready is high only while idle, so a new transfer waits until the last result is
// loaded; during a scan the single RAM read port reads one palette entry per cycle.
// Reset: synchronous, active low; per-entry valid flags make every entry read as zero.
`include "assert_macros.svh"

module palette_nearest_color_match
    import pnc_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_func,
    input  logic [7:0] s_entry_index,
    input  logic [7:0] s_red,
    input  logic [7:0] s_green,
    input  logic [7:0] s_blue,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_best_index
);

    localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(PALETTE_ENTRIES - 1);
    localparam logic [8:0] ENTRY_LIMIT = 9'(PALETTE_ENTRIES);

    function automatic logic [DIST_W-1:0] sq_diff(input logic [CH_W-1:0] a,
                                                  input logic [CH_W-1:0] b);
        logic [CH_W-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return DIST_W'(d) * DIST_W'(d);
    endfunction

    pnc_state_t state_reg, state_next;

    logic              issue, start, out_load, wr_en;
    logic [IDX_W-1:0]  addr_reg;
    logic [CH_W-1:0]   r6_reg, g6_reg, b6_reg;
    logic [PALETTE_ENTRIES-1:0] valid_bits_reg;

    logic [COLOR_W-1:0] ram_rdata, entry;
    logic               s1_valid_reg, s1_last_reg, s1_hit_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic [DIST_W-1:0]  s1_dist;

    logic               s2_valid_reg, s2_last_reg;
    logic [IDX_W-1:0]   s2_idx_reg;
    logic [DIST_W-1:0]  s2_dist_reg;

    logic [DIST_W-1:0]  least_sq_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic               s3_last_reg;

    logic               m_valid_reg;
    logic [7:0]         m_best_index_reg;

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        issue      = 1'b0;
        start      = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && s_func == FUNC_MATCH) begin
                    start      = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                issue = 1'b1;
                if (addr_reg == LAST_ADDR) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (s3_last_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Writes beyond the configured palette size are dropped.
    assign wr_en = s_valid && s_ready && s_func == FUNC_WRITE
                   && ({1'b0, s_entry_index} < ENTRY_LIMIT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_bits_reg <= '0;
        end else if (wr_en) begin
            valid_bits_reg[s_entry_index[IDX_W-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            addr_reg <= '0;
            r6_reg   <= s_red[7:2];
            g6_reg   <= s_green[7:2];
            b6_reg   <= s_blue[7:2];
        end else if (issue) begin
            addr_reg <= addr_reg + 1'b1;
        end
    end

    pnc_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (s_entry_index[IDX_W-1:0]),
        .wdata ({s_red[7:2], s_green[7:2], s_blue[7:2]}),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // Stage 1: RAM data arrives; an entry never written reads as black.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= issue;
        end
        s1_last_reg <= issue && addr_reg == LAST_ADDR;
        s1_hit_reg  <= valid_bits_reg[addr_reg];
        s1_idx_reg  <= addr_reg;
    end

    assign entry   = s1_hit_reg ? ram_rdata : '0;
    assign s1_dist = sq_diff(entry[3*CH_W-1:2*CH_W], r6_reg)
                   + sq_diff(entry[2*CH_W-1:CH_W], g6_reg)
                   + sq_diff(entry[CH_W-1:0], b6_reg);

    // Stage 2: registered distance.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s1_valid_reg;
        end
        s2_last_reg <= s1_valid_reg && s1_last_reg;
        s2_idx_reg  <= s1_idx_reg;
        s2_dist_reg <= s1_dist;
    end

    // Stage 3: a strict compare keeps the lowest index among equal distances.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_last_reg <= 1'b0;
        end else begin
            s3_last_reg <= s2_valid_reg && s2_last_reg;
        end
        if (start) begin
            least_sq_reg <= NO_DIST;
            best_idx_reg <= '0;
        end else if (s2_valid_reg && s2_dist_reg < least_sq_reg) begin
            least_sq_reg <= s2_dist_reg;
            best_idx_reg <= s2_idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (out_load) begin
            m_best_index_reg <= 8'(best_idx_reg);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_best_index = m_best_index_reg;

    `PNC_ASSERT_NOW(a_scan_addr_in_range, aclk, aresetn, state_reg == ST_SCAN,
        addr_reg <= LAST_ADDR, "scan address beyond the palette")
    `PNC_ASSERT_NEXT(a_write_stays_idle, aclk, aresetn,
        s_valid && s_ready && s_func == FUNC_WRITE,
        state_reg == ST_IDLE, "a write transfer started a scan")
    `PNC_ASSERT_NOW(a_last_only_in_drain, aclk, aresetn, s3_last_reg,
        state_reg == ST_DRAIN, "scan finished outside the drain state")
    `PNC_ASSERT_NEXT(a_best_never_grows, aclk, aresetn, state_reg != ST_IDLE,
        least_sq_reg <= $past(least_sq_reg), "best distance increased during a scan")

endmodule
